// ===== design/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DPSVM_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dpsvm assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define DPSVM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dpsvm assertion failed");

`endif

// ===== design/dpsvm_pkg.sv =====
`timescale 1ns / 1ps

package dpsvm_pkg;

   localparam int VOLT_WIDTH     = 16;
   localparam int DUTY_FRAC_BITS = 15;
   localparam int DUTY_WIDTH     = DUTY_FRAC_BITS + 1;
   localparam int GAIN_WIDTH     = 16;
   localparam int SPLIT_ONE      = 16384;
   localparam int CSR_WIDTH      = 15;
   localparam logic [CSR_WIDTH-1:0] CSR_RESET = CSR_WIDTH'(64);
   localparam int SECT_WIDTH     = 3;
   localparam int STATUS_WIDTH   = 3;

   // Split reference, sqrt3/2 product, numerator and quotient widths.
   localparam int PROD_WIDTH  = VOLT_WIDTH + GAIN_WIDTH;
   localparam int CONST_WIDTH = 18;
   localparam logic signed [CONST_WIDTH-1:0] K_HALF_SQRT3 = CONST_WIDTH'(56756);
   localparam int MUL_WIDTH   = PROD_WIDTH + CONST_WIDTH;
   localparam int NUM_WIDTH   = PROD_WIDTH + 19;
   localparam int MAG_WIDTH   = NUM_WIDTH - 1;
   localparam int QUOT_WIDTH  = MAG_WIDTH + 1;
   localparam int SUM_WIDTH   = QUOT_WIDTH + 3;
   localparam int Q30_SHIFT   = 30;

   localparam int NUM_PORTS  = 2;
   localparam int PORT_UPPER = 0;
   localparam int PORT_LOWER = 1;

   localparam int NUM_LANES    = 4;
   localparam int LANE_UPPER_X = 0;
   localparam int LANE_UPPER_Y = 1;
   localparam int LANE_LOWER_X = 2;
   localparam int LANE_LOWER_Y = 3;

   localparam int STATUS_LOW_DC  = 0;
   localparam int STATUS_OVERMOD = 1;
   localparam int STATUS_CLAMP   = 2;

   typedef enum logic [SECT_WIDTH-1:0] {
      SECTOR_1 = 3'd1,
      SECTOR_2 = 3'd2,
      SECTOR_3 = 3'd3,
      SECTOR_4 = 3'd4,
      SECTOR_5 = 3'd5,
      SECTOR_6 = 3'd6
   } sector_type;

   typedef struct packed {
      logic signed [VOLT_WIDTH-1:0] alpha_voltage;
      logic signed [VOLT_WIDTH-1:0] beta_voltage;
      logic signed [GAIN_WIDTH-1:0] split_factor;
      logic signed [VOLT_WIDTH-1:0] upper_dc_voltage;
      logic signed [VOLT_WIDTH-1:0] lower_dc_voltage;
   } req_type;

   typedef struct packed {
      logic [DUTY_WIDTH-1:0]   upper_duty_a;
      logic [DUTY_WIDTH-1:0]   upper_duty_b;
      logic [DUTY_WIDTH-1:0]   upper_duty_c;
      logic [SECT_WIDTH-1:0]   upper_sector;
      logic [STATUS_WIDTH-1:0] upper_status;
      logic [DUTY_WIDTH-1:0]   lower_duty_a;
      logic [DUTY_WIDTH-1:0]   lower_duty_b;
      logic [DUTY_WIDTH-1:0]   lower_duty_c;
      logic [SECT_WIDTH-1:0]   lower_sector;
      logic [STATUS_WIDTH-1:0] lower_status;
      logic [STATUS_WIDTH-1:0] combined_status;
   } rsp_type;

   typedef struct packed {
      sector_type sector;
      logic       low;
      logic       neg_x;
      logic       neg_y;
   } port_side_type;

   typedef struct packed {
      port_side_type upper;
      port_side_type lower;
   } side_type;

   // One division in flight: partial remainder, dividend bits being
   // consumed from the top while quotient bits enter at the bottom.
   typedef struct packed {
      logic [VOLT_WIDTH-1:0] rem;
      logic [MAG_WIDTH-1:0]  dq;
      logic [VOLT_WIDTH-1:0] dvs;
   } div_lane_type;

endpackage

// ===== design/dpsvm_div_cell.sv =====
`timescale 1ns / 1ps

module dpsvm_div_cell (
   input  logic                   clock,
   input  logic                   adv,
   input  dpsvm_pkg::div_lane_type lane_in,
   output dpsvm_pkg::div_lane_type lane_out
);

   localparam int VW = dpsvm_pkg::VOLT_WIDTH;
   localparam int MW = dpsvm_pkg::MAG_WIDTH;

   logic [VW:0]            trial;
   logic [VW:0]            diff;
   logic                   fits;
   dpsvm_pkg::div_lane_type cell_in;
   dpsvm_pkg::div_lane_type cell_ff;

   // One restoring step: bring down the next dividend bit and subtract if it fits.
   always_comb begin
      trial       = {lane_in.rem, lane_in.dq[MW-1]};
      diff        = trial - {1'b0, lane_in.dvs};
      fits        = trial >= {1'b0, lane_in.dvs};
      cell_in.dvs = lane_in.dvs;
      cell_in.rem = fits ? diff[VW-1:0] : trial[VW-1:0];
      cell_in.dq  = {lane_in.dq[MW-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         cell_ff <= cell_in;
      end
   end

   assign lane_out = cell_ff;

endmodule

// ===== design/dpsvm_div_chain.sv =====
`timescale 1ns / 1ps

module dpsvm_div_chain (
   input  logic                                               clock,
   input  logic                                               reset,
   input  logic                                               adv,
   input  logic                                               in_valid,
   input  dpsvm_pkg::div_lane_type [dpsvm_pkg::NUM_LANES-1:0] lanes_in,
   input  dpsvm_pkg::side_type                                side_in,
   output logic                                               out_valid,
   output dpsvm_pkg::div_lane_type [dpsvm_pkg::NUM_LANES-1:0] lanes_out,
   output dpsvm_pkg::side_type                                side_out
);

   localparam int STAGES = dpsvm_pkg::MAG_WIDTH;
   localparam int LANES  = dpsvm_pkg::NUM_LANES;

   dpsvm_pkg::div_lane_type [LANES-1:0] lane_bus [STAGES+1];
   logic [STAGES-1:0]                   valid_ff;
   logic [STAGES-1:0]                   valid_in;
   dpsvm_pkg::side_type                 side_ff [STAGES];

   assign lane_bus[0] = lanes_in;

   for (genvar s = 0; s < STAGES; s++) begin : g_stage
      for (genvar l = 0; l < LANES; l++) begin : g_lane
         dpsvm_div_cell u_cell (
            .clock    (clock),
            .adv      (adv),
            .lane_in  (lane_bus[s][l]),
            .lane_out (lane_bus[s+1][l])
         );
      end
   end

   assign valid_in = {valid_ff[STAGES-2:0], in_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         side_ff[0] <= side_in;
         for (int s = 1; s < STAGES; s++) begin
            side_ff[s] <= side_ff[s-1];
         end
      end
   end

   assign out_valid = valid_ff[STAGES-1];
   assign lanes_out = lane_bus[STAGES];
   assign side_out  = side_ff[STAGES-1];

endmodule

// ===== design/dpsvm_front.sv =====
`timescale 1ns / 1ps

module dpsvm_front (
   input  logic                                               clock,
   input  logic                                               reset,
   input  logic                                               adv,
   input  logic                                               in_valid,
   input  dpsvm_pkg::req_type                                 req,
   input  logic [dpsvm_pkg::CSR_WIDTH-1:0]                    dc_low_limit,
   output logic                                               out_valid,
   output dpsvm_pkg::div_lane_type [dpsvm_pkg::NUM_LANES-1:0] lanes,
   output dpsvm_pkg::side_type                                side
);

   localparam int VW = dpsvm_pkg::VOLT_WIDTH;
   localparam int GW = dpsvm_pkg::GAIN_WIDTH;
   localparam int PW = dpsvm_pkg::PROD_WIDTH;
   localparam int XW = dpsvm_pkg::MUL_WIDTH;
   localparam int NW = dpsvm_pkg::NUM_WIDTH;
   localparam int MW = dpsvm_pkg::MAG_WIDTH;
   localparam int NP = dpsvm_pkg::NUM_PORTS;
   localparam int UP = dpsvm_pkg::PORT_UPPER;
   localparam int LO = dpsvm_pkg::PORT_LOWER;

   function automatic dpsvm_pkg::sector_type sector_of_code(input logic [2:0] code);
      dpsvm_pkg::sector_type s;
      unique case (code)
         3'd1:    s = dpsvm_pkg::SECTOR_4;
         3'd2:    s = dpsvm_pkg::SECTOR_6;
         3'd3:    s = dpsvm_pkg::SECTOR_5;
         3'd4:    s = dpsvm_pkg::SECTOR_2;
         3'd5:    s = dpsvm_pkg::SECTOR_3;
         default: s = dpsvm_pkg::SECTOR_1;
      endcase
      return s;
   endfunction

   logic valid1_ff, valid2_ff, valid3_ff, valid4_ff, valid5_ff;

   // Stage 1: capture and clamp the split factor.
   logic signed [GW-1:0] split_clamped;
   logic signed [VW-1:0] alpha_ff, beta_ff;
   logic signed [GW-1:0] gain_ff [NP];
   logic signed [VW-1:0] vdc1_ff [NP];

   always_comb begin
      priority if (req.split_factor < 0) begin
         split_clamped = '0;
      end else if (req.split_factor > GW'(dpsvm_pkg::SPLIT_ONE)) begin
         split_clamped = GW'(dpsvm_pkg::SPLIT_ONE);
      end else begin
         split_clamped = req.split_factor;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         alpha_ff    <= req.alpha_voltage;
         beta_ff     <= req.beta_voltage;
         gain_ff[UP] <= GW'(dpsvm_pkg::SPLIT_ONE) - split_clamped;
         gain_ff[LO] <= split_clamped;
         vdc1_ff[UP] <= req.upper_dc_voltage;
         vdc1_ff[LO] <= req.lower_dc_voltage;
      end
   end

   // Stage 2: split reference per port.
   logic signed [PW-1:0] ref_a2_ff [NP];
   logic signed [PW-1:0] ref_b2_ff [NP];
   logic signed [VW-1:0] vdc2_ff [NP];

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int p = 0; p < NP; p++) begin
            ref_a2_ff[p] <= alpha_ff * gain_ff[p];
            ref_b2_ff[p] <= beta_ff * gain_ff[p];
            vdc2_ff[p]   <= vdc1_ff[p];
         end
      end
   end

   // Stage 3: sqrt3/2 products; sqrt3 terms are these doubled.
   logic signed [PW-1:0] ref_a3_ff [NP];
   logic signed [PW-1:0] ref_b3_ff [NP];
   logic signed [XW-1:0] mul_a3_ff [NP];
   logic signed [XW-1:0] mul_b3_ff [NP];
   logic signed [VW-1:0] vdc3_ff [NP];

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int p = 0; p < NP; p++) begin
            mul_a3_ff[p] <= ref_a2_ff[p] * dpsvm_pkg::K_HALF_SQRT3;
            mul_b3_ff[p] <= ref_b2_ff[p] * dpsvm_pkg::K_HALF_SQRT3;
            ref_a3_ff[p] <= ref_a2_ff[p];
            ref_b3_ff[p] <= ref_b2_ff[p];
            vdc3_ff[p]   <= vdc2_ff[p];
         end
      end
   end

   // Stage 4: sector tests, 1.5*A, DC magnitude and low-voltage check.
   logic signed [NW-1:0]    ext_a [NP];
   logic signed [NW-1:0]    ext_b [NP];
   logic signed [NW-1:0]    ext_ma [NP];
   logic signed [NW-1:0]    ext_mb [NP];
   logic signed [NW-1:0]    test_b [NP];
   logic signed [NW-1:0]    test_c [NP];
   logic [2:0]              code4 [NP];
   logic [VW-1:0]           vmag4 [NP];
   dpsvm_pkg::sector_type   sect4_ff [NP];
   logic signed [NW-1:0]    p15a4_ff [NP];
   logic signed [NW-1:0]    phb4_ff [NP];
   logic signed [NW-1:0]    psb4_ff [NP];
   logic [VW-1:0]           vmag4_ff [NP];
   logic                    vneg4_ff [NP];
   logic                    low4_ff [NP];

   always_comb begin
      for (int p = 0; p < NP; p++) begin
         ext_a[p]  = NW'(ref_a3_ff[p]);
         ext_b[p]  = NW'(ref_b3_ff[p]);
         ext_ma[p] = NW'(mul_a3_ff[p]);
         ext_mb[p] = NW'(mul_b3_ff[p]);
         test_b[p] = (ext_ma[p] <<< 1) - (ext_b[p] <<< 16);
         test_c[p] = -(ext_ma[p] <<< 1) - (ext_b[p] <<< 16);
         code4[p]  = {ext_b[p] > 0, test_b[p] > 0, test_c[p] > 0};
         vmag4[p]  = vdc3_ff[p][VW-1] ? VW'(-vdc3_ff[p]) : VW'(vdc3_ff[p]);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int p = 0; p < NP; p++) begin
            sect4_ff[p] <= sector_of_code(code4[p]);
            p15a4_ff[p] <= (ext_a[p] <<< 16) + (ext_a[p] <<< 15);
            phb4_ff[p]  <= ext_mb[p];
            psb4_ff[p]  <= ext_mb[p] <<< 1;
            vmag4_ff[p] <= vmag4[p];
            vneg4_ff[p] <= vdc3_ff[p][VW-1];
            low4_ff[p]  <= vmag4[p] <= VW'(dc_low_limit);
         end
      end
   end

   // Stage 5: pick the sector's numerators and split them into sign and magnitude.
   logic signed [NW-1:0]    num_x [NP];
   logic signed [NW-1:0]    num_y [NP];
   dpsvm_pkg::port_side_type port_side [NP];
   dpsvm_pkg::div_lane_type  lane_x [NP];
   dpsvm_pkg::div_lane_type  lane_y [NP];
   dpsvm_pkg::div_lane_type [dpsvm_pkg::NUM_LANES-1:0] lanes_ff;
   dpsvm_pkg::side_type      side_ff;

   always_comb begin
      for (int p = 0; p < NP; p++) begin
         unique case (sect4_ff[p])
            dpsvm_pkg::SECTOR_1: begin
               num_x[p] = p15a4_ff[p] - phb4_ff[p];
               num_y[p] = psb4_ff[p];
            end
            dpsvm_pkg::SECTOR_2: begin
               num_x[p] = -p15a4_ff[p] + phb4_ff[p];
               num_y[p] = p15a4_ff[p] + phb4_ff[p];
            end
            dpsvm_pkg::SECTOR_3: begin
               num_x[p] = -p15a4_ff[p] - phb4_ff[p];
               num_y[p] = psb4_ff[p];
            end
            dpsvm_pkg::SECTOR_4: begin
               num_x[p] = -p15a4_ff[p] + phb4_ff[p];
               num_y[p] = -psb4_ff[p];
            end
            dpsvm_pkg::SECTOR_5: begin
               num_x[p] = p15a4_ff[p] - phb4_ff[p];
               num_y[p] = -p15a4_ff[p] - phb4_ff[p];
            end
            default: begin
               num_x[p] = p15a4_ff[p] + phb4_ff[p];
               num_y[p] = -psb4_ff[p];
            end
         endcase
         lane_x[p].rem = '0;
         lane_x[p].dvs = vmag4_ff[p];
         lane_x[p].dq  = num_x[p][NW-1] ? MW'(-num_x[p]) : MW'(num_x[p]);
         lane_y[p].rem = '0;
         lane_y[p].dvs = vmag4_ff[p];
         lane_y[p].dq  = num_y[p][NW-1] ? MW'(-num_y[p]) : MW'(num_y[p]);
         port_side[p].sector = sect4_ff[p];
         port_side[p].low    = low4_ff[p];
         port_side[p].neg_x  = num_x[p][NW-1] ^ vneg4_ff[p];
         port_side[p].neg_y  = num_y[p][NW-1] ^ vneg4_ff[p];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         lanes_ff[dpsvm_pkg::LANE_UPPER_X] <= lane_x[UP];
         lanes_ff[dpsvm_pkg::LANE_UPPER_Y] <= lane_y[UP];
         lanes_ff[dpsvm_pkg::LANE_LOWER_X] <= lane_x[LO];
         lanes_ff[dpsvm_pkg::LANE_LOWER_Y] <= lane_y[LO];
         side_ff.upper <= port_side[UP];
         side_ff.lower <= port_side[LO];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
         valid2_ff <= 1'b0;
         valid3_ff <= 1'b0;
         valid4_ff <= 1'b0;
         valid5_ff <= 1'b0;
      end else if (adv) begin
         valid1_ff <= in_valid;
         valid2_ff <= valid1_ff;
         valid3_ff <= valid2_ff;
         valid4_ff <= valid3_ff;
         valid5_ff <= valid4_ff;
      end
   end

   assign out_valid = valid5_ff;
   assign lanes     = lanes_ff;
   assign side      = side_ff;

endmodule

// ===== design/dpsvm_back.sv =====
`timescale 1ns / 1ps

module dpsvm_back (
   input  logic                                               clock,
   input  logic                                               reset,
   input  logic                                               adv,
   input  logic                                               in_valid,
   input  dpsvm_pkg::div_lane_type [dpsvm_pkg::NUM_LANES-1:0] lanes,
   input  dpsvm_pkg::side_type                                side,
   output logic                                               out_valid,
   output dpsvm_pkg::rsp_type                                 rsp
);

   localparam int MW = dpsvm_pkg::MAG_WIDTH;
   localparam int QW = dpsvm_pkg::QUOT_WIDTH;
   localparam int SW = dpsvm_pkg::SUM_WIDTH;
   localparam int DW = dpsvm_pkg::DUTY_WIDTH;
   localparam int FB = dpsvm_pkg::DUTY_FRAC_BITS;
   localparam int QS = dpsvm_pkg::Q30_SHIFT;
   localparam int NP = dpsvm_pkg::NUM_PORTS;
   localparam int NL = dpsvm_pkg::NUM_LANES;
   localparam int UP = dpsvm_pkg::PORT_UPPER;
   localparam int LO = dpsvm_pkg::PORT_LOWER;
   localparam logic signed [SW-1:0] DUTY_ONE = SW'(64'd1 << QS);
   localparam logic signed [SW-1:0] DUTY_RND = SW'(64'd1 << (QS - 1 - FB));

   function automatic logic out_of_range(input logic signed [SW-1:0] v);
      return (v < 0) || (v > DUTY_ONE);
   endfunction

   function automatic logic [DW-1:0] finish_duty(input logic signed [SW-1:0] v);
      logic signed [SW-1:0] rounded;
      rounded = v + DUTY_RND;
      priority if (v < 0) begin
         return '0;
      end else if (v > DUTY_ONE) begin
         return DW'(64'd1 << FB);
      end else begin
         return rounded[QS:QS-FB];
      end
   endfunction

   logic valid1_ff, valid2_ff, valid3_ff;
   dpsvm_pkg::side_type side1_ff, side2_ff, side3_ff;

   // Stage 1: apply the quotient signs.
   logic                 lane_neg [NL];
   logic signed [QW-1:0] duty1_ff [NL];

   always_comb begin
      lane_neg[dpsvm_pkg::LANE_UPPER_X] = side.upper.neg_x;
      lane_neg[dpsvm_pkg::LANE_UPPER_Y] = side.upper.neg_y;
      lane_neg[dpsvm_pkg::LANE_LOWER_X] = side.lower.neg_x;
      lane_neg[dpsvm_pkg::LANE_LOWER_Y] = side.lower.neg_y;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int l = 0; l < NL; l++) begin
            duty1_ff[l] <= lane_neg[l] ? -$signed({1'b0, lanes[l].dq})
                                       : $signed({1'b0, lanes[l].dq});
         end
         side1_ff <= side;
      end
   end

   // Stage 2: active sum and, for the lower port, the zero-vector duty.
   logic signed [SW-1:0] dx1 [NP];
   logic signed [SW-1:0] dy1 [NP];
   logic signed [SW-1:0] zero1 [NP];
   logic signed [SW-1:0] dx2_ff [NP];
   logic signed [SW-1:0] dy2_ff [NP];
   logic signed [SW-1:0] sum2_ff [NP];
   logic signed [SW-1:0] zero2_ff [NP];
   logic                 ovm2_ff [NP];

   always_comb begin
      for (int p = 0; p < NP; p++) begin
         dx1[p] = SW'(duty1_ff[2 * p]);
         dy1[p] = SW'(duty1_ff[2 * p + 1]);
      end
      zero1[UP] = '0;
      zero1[LO] = DUTY_ONE - dx1[LO] - dy1[LO];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int p = 0; p < NP; p++) begin
            dx2_ff[p]   <= dx1[p];
            dy2_ff[p]   <= dy1[p];
            sum2_ff[p]  <= dx1[p] + dy1[p];
            zero2_ff[p] <= zero1[p];
            ovm2_ff[p]  <= zero1[p] < 0;
         end
         side2_ff <= side1_ff;
      end
   end

   // Stage 3: phase duties by sector.
   dpsvm_pkg::sector_type sect2 [NP];
   logic signed [SW-1:0]  ph_a [NP];
   logic signed [SW-1:0]  ph_b [NP];
   logic signed [SW-1:0]  ph_c [NP];
   logic signed [SW-1:0]  ph_a3_ff [NP];
   logic signed [SW-1:0]  ph_b3_ff [NP];
   logic signed [SW-1:0]  ph_c3_ff [NP];
   logic                  ovm3_ff [NP];

   assign sect2[UP] = side2_ff.upper.sector;
   assign sect2[LO] = side2_ff.lower.sector;

   always_comb begin
      for (int p = 0; p < NP; p++) begin
         unique case (sect2[p])
            dpsvm_pkg::SECTOR_1: begin
               ph_a[p] = sum2_ff[p] + zero2_ff[p];
               ph_b[p] = dy2_ff[p] + zero2_ff[p];
               ph_c[p] = zero2_ff[p];
            end
            dpsvm_pkg::SECTOR_2: begin
               ph_a[p] = dy2_ff[p] + zero2_ff[p];
               ph_b[p] = sum2_ff[p] + zero2_ff[p];
               ph_c[p] = zero2_ff[p];
            end
            dpsvm_pkg::SECTOR_3: begin
               ph_a[p] = zero2_ff[p];
               ph_b[p] = sum2_ff[p] + zero2_ff[p];
               ph_c[p] = dx2_ff[p] + zero2_ff[p];
            end
            dpsvm_pkg::SECTOR_4: begin
               ph_a[p] = zero2_ff[p];
               ph_b[p] = dx2_ff[p] + zero2_ff[p];
               ph_c[p] = sum2_ff[p] + zero2_ff[p];
            end
            dpsvm_pkg::SECTOR_5: begin
               ph_a[p] = dx2_ff[p] + zero2_ff[p];
               ph_b[p] = zero2_ff[p];
               ph_c[p] = sum2_ff[p] + zero2_ff[p];
            end
            default: begin
               ph_a[p] = sum2_ff[p] + zero2_ff[p];
               ph_b[p] = zero2_ff[p];
               ph_c[p] = dy2_ff[p] + zero2_ff[p];
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int p = 0; p < NP; p++) begin
            ph_a3_ff[p] <= ph_a[p];
            ph_b3_ff[p] <= ph_b[p];
            ph_c3_ff[p] <= ph_c[p];
            ovm3_ff[p]  <= ovm2_ff[p];
         end
         side3_ff <= side2_ff;
      end
   end

   // Clamp, round and flag; a low DC link forces the fixed idle answer.
   dpsvm_pkg::port_side_type              side3 [NP];
   logic [DW-1:0]                         duty_a [NP];
   logic [DW-1:0]                         duty_b [NP];
   logic [DW-1:0]                         duty_c [NP];
   logic [dpsvm_pkg::SECT_WIDTH-1:0]      sect_o [NP];
   logic [dpsvm_pkg::STATUS_WIDTH-1:0]    stat_o [NP];

   assign side3[UP] = side3_ff.upper;
   assign side3[LO] = side3_ff.lower;

   always_comb begin
      for (int p = 0; p < NP; p++) begin
         stat_o[p] = '0;
         if (side3[p].low) begin
            duty_a[p] = '0;
            duty_b[p] = '0;
            duty_c[p] = '0;
            sect_o[p] = dpsvm_pkg::SECTOR_1;
            stat_o[p][dpsvm_pkg::STATUS_LOW_DC] = 1'b1;
         end else begin
            duty_a[p] = finish_duty(ph_a3_ff[p]);
            duty_b[p] = finish_duty(ph_b3_ff[p]);
            duty_c[p] = finish_duty(ph_c3_ff[p]);
            sect_o[p] = side3[p].sector;
            stat_o[p][dpsvm_pkg::STATUS_OVERMOD] = ovm3_ff[p];
            stat_o[p][dpsvm_pkg::STATUS_CLAMP]   = out_of_range(ph_a3_ff[p])
                                                || out_of_range(ph_b3_ff[p])
                                                || out_of_range(ph_c3_ff[p]);
         end
      end
   end

   always_comb begin
      rsp.upper_duty_a    = duty_a[UP];
      rsp.upper_duty_b    = duty_b[UP];
      rsp.upper_duty_c    = duty_c[UP];
      rsp.upper_sector    = sect_o[UP];
      rsp.upper_status    = stat_o[UP];
      rsp.lower_duty_a    = duty_a[LO];
      rsp.lower_duty_b    = duty_b[LO];
      rsp.lower_duty_c    = duty_c[LO];
      rsp.lower_sector    = sect_o[LO];
      rsp.lower_status    = stat_o[LO];
      rsp.combined_status = stat_o[UP] | stat_o[LO];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
         valid2_ff <= 1'b0;
         valid3_ff <= 1'b0;
      end else if (adv) begin
         valid1_ff <= in_valid;
         valid2_ff <= valid1_ff;
         valid3_ff <= valid2_ff;
      end
   end

   assign out_valid = valid3_ff;

endmodule

// ===== design/dual_port_space_vector_modulator.sv =====
`timescale 1ns / 1ps
// Pipeline from an accepted request beat to its response beat: 5 front stages, one
// divider cell row per quotient bit, 3 back stages and the output register.
// Throughput: one beat per cycle when not stalled, in the divider's cell chain as well.
// Reset: synchronous, active high; empties the pipeline and loads the low-voltage
// threshold of the DC links with 64.

module dual_port_space_vector_modulator (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  dpsvm_pkg::req_type                req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output dpsvm_pkg::rsp_type                rsp_data,
   input  logic                              csr_write_enable,
   input  logic [dpsvm_pkg::CSR_WIDTH-1:0]   csr_write_data
);

   localparam int NL = dpsvm_pkg::NUM_LANES;

   // The whole pipeline moves as one. It advances whenever its last stage is
   // empty or the output register can take that beat, so bubbles ahead of a
   // stalled response are still filled with new request beats.
   logic adv;
   logic front_valid, chain_valid, back_valid;
   dpsvm_pkg::div_lane_type [NL-1:0] front_lanes, chain_lanes;
   dpsvm_pkg::side_type              front_side, chain_side;
   dpsvm_pkg::rsp_type               back_rsp;

   logic [dpsvm_pkg::CSR_WIDTH-1:0] min_dc_ff;
   logic                            rsp_valid_ff, rsp_valid_in;
   dpsvm_pkg::rsp_type              rsp_data_ff;

   assign adv       = !back_valid || !rsp_valid_ff || rsp_ready;
   assign req_ready = adv;

   // Users must write the threshold register only while the block is idle (unenforced).
   always_ff @(posedge clock) begin
      if (reset) begin
         min_dc_ff <= dpsvm_pkg::CSR_RESET;
      end else if (csr_write_enable) begin
         min_dc_ff <= csr_write_data;
      end
   end

   // Front end: split the reference, find the sector and build the two
   // numerators per port with the DC link magnitude as divisor.
   dpsvm_front u_front (
      .clock        (clock),
      .reset        (reset),
      .adv          (adv),
      .in_valid     (req_valid),
      .req          (req_data),
      .dc_low_limit (min_dc_ff),
      .out_valid    (front_valid),
      .lanes        (front_lanes),
      .side         (front_side)
   );

   // Four divisions run side by side, one quotient bit per cell row.
   dpsvm_div_chain u_chain (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (front_valid),
      .lanes_in  (front_lanes),
      .side_in   (front_side),
      .out_valid (chain_valid),
      .lanes_out (chain_lanes),
      .side_out  (chain_side)
   );

   // Back end: signed duties, zero-vector time for the lower port, phase
   // assembly, clamp and rounding to Q1.15.
   dpsvm_back u_back (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (chain_valid),
      .lanes     (chain_lanes),
      .side      (chain_side),
      .out_valid (back_valid),
      .rsp       (back_rsp)
   );

   // Output register: loads a finished beat when one arrives and the slot is
   // free or draining, otherwise holds until the consumer takes it.
   always_comb begin
      priority if (back_valid && adv) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (back_valid && adv) begin
         rsp_data_ff <= back_rsp;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== design/dpsvm_checker.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dpsvm_checker (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input dpsvm_pkg::rsp_type rsp_data
);

   `DPSVM_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `DPSVM_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_data))
   `DPSVM_ASSERT_SAME(a_combined, clock, reset, rsp_valid, rsp_data.combined_status == (rsp_data.upper_status | rsp_data.lower_status))
   `DPSVM_ASSERT_SAME(a_sector, clock, reset, rsp_valid, rsp_data.upper_sector != 3'd0 && rsp_data.upper_sector != 3'd7 && rsp_data.lower_sector != 3'd0 && rsp_data.lower_sector != 3'd7)
   `DPSVM_ASSERT_SAME(a_low_dc, clock, reset, rsp_valid && rsp_data.lower_status[0], rsp_data.lower_duty_a == '0 && rsp_data.lower_duty_b == '0 && rsp_data.lower_duty_c == '0 && rsp_data.lower_status == 3'd1)

endmodule

bind dual_port_space_vector_modulator dpsvm_checker u_dpsvm_checker (.*);

// ===== test/tb.sv =====
`timescale 1ns / 1ps

module tb;
   import dpsvm_pkg::*;

   // The clock period is 12 ns. After the last expected beat arrives, the bench waits
   // this many cycles, which covers the pipeline latency with some margin.
   localparam int CLOCK_PERIOD = 12;
   localparam int DRAIN_CYCLES = 70;
   localparam int RANDOM_ITEMS = 1800;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   req_type            req_data;
   logic               rsp_valid;
   logic               rsp_ready;
   rsp_type            rsp_data;
   logic               csr_write_enable;
   logic [CSR_WIDTH-1:0] csr_write_data;

   dual_port_space_vector_modulator u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   // The bench keeps its own copy of the low-voltage threshold register.
   // The register is only written while the pipeline is idle.
   logic [CSR_WIDTH-1:0] min_dc_level;

   req_type pending_requests[$];
   rsp_type expected_duties[$];
   int      error_count;
   logic    req_fire;

   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   // The split factor saturates to the range 0 to 16384, in Q14.
   function automatic longint clamp_split(longint k);
      if (k < 0) return 0;
      if (k > SPLIT_ONE) return SPLIT_ONE;
      return k;
   endfunction

   // This function clamps one Q30 phase duty to 0..1 and flags any clamping.
   // It then rounds half up to the output Q1.15 format.
   function automatic logic [DUTY_WIDTH-1:0] settle_duty(longint v, inout logic [2:0] st);
      longint one;
      one = longint'(1) <<< 30;
      if (v < 0) begin
         st[STATUS_CLAMP] = 1'b1;
         return '0;
      end
      if (v > one) begin
         st[STATUS_CLAMP] = 1'b1;
         return DUTY_WIDTH'(1) << DUTY_FRAC_BITS;
      end
      return DUTY_WIDTH'((v + (longint'(1) <<< (29 - DUTY_FRAC_BITS))) >>> (30 - DUTY_FRAC_BITS));
   endfunction

   // Each active duty is saturated to plus or minus 2^61.
   function automatic longint saturate_duty(longint v);
      longint lim;
      lim = longint'(1) <<< 61;
      if (v > lim) return lim;
      if (v < -lim) return -lim;
      return v;
   endfunction

   // This function computes the duties, sector and flags of one port.
   // The port's reference is already scaled by its share of the split, in Q14.
   function automatic void modulate_port(input longint a, input longint b, input longint vdc,
                                         input bit lower, output logic [DUTY_WIDTH-1:0] da,
                                         output logic [DUTY_WIDTH-1:0] db,
                                         output logic [DUTY_WIDTH-1:0] dc,
                                         output logic [2:0] sect, output logic [2:0] st);
      longint     mag, p15a, phb, psb, x, y, dx, dy, d0, ta, tb, tc;
      logic [2:0] code;
      sector_type sector;
      st  = '0;
      mag = (vdc < 0) ? -vdc : vdc;
      if (mag <= longint'(min_dc_level)) begin
         da = '0;
         db = '0;
         dc = '0;
         sect = SECTOR_1;
         st[STATUS_LOW_DC] = 1'b1;
         return;
      end
      code[2] = b > 0;
      code[1] = (113512 * a - 65536 * b) > 0;
      code[0] = (-113512 * a - 65536 * b) > 0;
      // The sector comes from three sign tests. A zero reference gives code 0, and
      // that code falls back to sector 1.
      case (code)
         3'd1:    sector = SECTOR_4;
         3'd2:    sector = SECTOR_6;
         3'd3:    sector = SECTOR_5;
         3'd4:    sector = SECTOR_2;
         3'd5:    sector = SECTOR_3;
         default: sector = SECTOR_1;
      endcase
      p15a = 98304 * a;
      phb  = 56756 * b;
      psb  = 113512 * b;
      case (sector)
         SECTOR_1: begin x = p15a - phb;  y = psb;         end
         SECTOR_2: begin x = -p15a + phb; y = p15a + phb;  end
         SECTOR_3: begin x = -p15a - phb; y = psb;         end
         SECTOR_4: begin x = -p15a + phb; y = -psb;        end
         SECTOR_5: begin x = p15a - phb;  y = -p15a - phb; end
         default:  begin x = p15a + phb;  y = -psb;        end
      endcase
      // Signed division truncates toward zero. With a negative DC link, the duties
      // take the sign of the quotient.
      dx = saturate_duty(x / vdc);
      dy = saturate_duty(y / vdc);
      d0 = 0;
      // Only the lower port adds the zero-vector time. A negative zero-vector time
      // means overmodulation.
      if (lower) begin
         d0 = (longint'(1) <<< 30) - dx - dy;
         if (d0 < 0) st[STATUS_OVERMOD] = 1'b1;
      end
      case (sector)
         SECTOR_1: begin ta = dx + dy + d0; tb = dy + d0; tc = d0; end
         SECTOR_2: begin ta = dy + d0; tb = dx + dy + d0; tc = d0; end
         SECTOR_3: begin ta = d0; tb = dx + dy + d0; tc = dx + d0; end
         SECTOR_4: begin ta = d0; tb = dx + d0; tc = dx + dy + d0; end
         SECTOR_5: begin ta = dx + d0; tb = d0; tc = dx + dy + d0; end
         default:  begin ta = dx + dy + d0; tb = d0; tc = dy + d0; end
      endcase
      da   = settle_duty(ta, st);
      db   = settle_duty(tb, st);
      dc   = settle_duty(tc, st);
      sect = sector;
   endfunction

   // This function predicts the whole response beat for one request beat.
   // The lower port gets a share k of the reference, and the upper port gets 1 - k.
   function automatic rsp_type predict_duties(req_type r);
      rsp_type e;
      longint  k;
      k = clamp_split(longint'(r.split_factor));
      modulate_port(longint'(r.alpha_voltage) * (SPLIT_ONE - k),
                    longint'(r.beta_voltage) * (SPLIT_ONE - k),
                    longint'(r.upper_dc_voltage), 1'b0, e.upper_duty_a, e.upper_duty_b,
                    e.upper_duty_c, e.upper_sector, e.upper_status);
      modulate_port(longint'(r.alpha_voltage) * k, longint'(r.beta_voltage) * k,
                    longint'(r.lower_dc_voltage), 1'b1, e.lower_duty_a, e.lower_duty_b,
                    e.lower_duty_c, e.lower_sector, e.lower_status);
      e.combined_status = e.upper_status | e.lower_status;
      return e;
   endfunction

   // The driver runs in bursts of random length with random gaps between them.
   // It holds a beat steady until the block accepts it.
   int burst_left;
   int gap_left;

   always @(negedge clock) begin
      logic    next_valid;
      req_type next_data;
      next_valid = req_valid;
      next_data  = req_data;
      if (!reset && !(req_valid && !req_fire)) begin
         next_valid = 1'b0;
         if (gap_left > 0) begin
            gap_left = gap_left - 1;
         end else if (pending_requests.size() > 0) begin
            next_data  = pending_requests.pop_front();
            next_valid = 1'b1;
            burst_left = burst_left - 1;
            if (burst_left <= 0) begin
               burst_left = $urandom_range(1, 40);
               case ($urandom_range(0, 3))
                  0:       gap_left = 0;
                  1:       gap_left = $urandom_range(10, 30);
                  default: gap_left = $urandom_range(1, 5);
               endcase
            end
         end
      end
      req_valid <= next_valid;
      req_data  <= next_data;
   end

   // The receiver stalls on a pattern of its own. A counter picks a new random pattern
   // as it runs, so the stalls land on every phase of the pipeline.
   int stall_mode;
   int stall_count;

   always @(negedge clock) begin
      stall_count = stall_count + 1;
      if (stall_count % 256 == 0) stall_mode = $urandom_range(0, 3);
      case (stall_mode)
         0:       rsp_ready <= 1'b1;
         1:       rsp_ready <= (stall_count % 4) != 0;
         2:       rsp_ready <= $urandom_range(0, 1);
         default: rsp_ready <= (stall_count % 16) < 4;
      endcase
   end

   task automatic check_field(string name, longint exp_val, longint act_val);
      if (exp_val != act_val) begin
         $error("%s: expected %0d, got %0d", name, exp_val, act_val);
         error_count++;
      end
   endtask

   // The monitor predicts on each accepted request beat. It checks each accepted
   // response beat against the oldest prediction, one field at a time.
   always @(posedge clock) begin
      rsp_type e;
      req_fire <= req_valid && req_ready && !reset;
      if (!reset) begin
         if (req_valid && req_ready) expected_duties.push_back(predict_duties(req_data));
         if (rsp_valid && rsp_ready) begin
            if (expected_duties.size() == 0) begin
               $error("response beat with no request outstanding");
               error_count++;
            end else begin
               e = expected_duties.pop_front();
               check_field("upper_duty_a", e.upper_duty_a, rsp_data.upper_duty_a);
               check_field("upper_duty_b", e.upper_duty_b, rsp_data.upper_duty_b);
               check_field("upper_duty_c", e.upper_duty_c, rsp_data.upper_duty_c);
               check_field("upper_sector", e.upper_sector, rsp_data.upper_sector);
               check_field("upper_status", e.upper_status, rsp_data.upper_status);
               check_field("lower_duty_a", e.lower_duty_a, rsp_data.lower_duty_a);
               check_field("lower_duty_b", e.lower_duty_b, rsp_data.lower_duty_b);
               check_field("lower_duty_c", e.lower_duty_c, rsp_data.lower_duty_c);
               check_field("lower_sector", e.lower_sector, rsp_data.lower_sector);
               check_field("lower_status", e.lower_status, rsp_data.lower_status);
               check_field("combined_status", e.combined_status, rsp_data.combined_status);
            end
         end
      end
   end

   function automatic logic signed [VOLT_WIDTH-1:0] pick_reference();
      case ($urandom_range(0, 5))
         0:       return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
         1:       return VOLT_WIDTH'($signed($urandom_range(0, 510)) - 255);
         default: return VOLT_WIDTH'($urandom);
      endcase
   endfunction

   // DC link values tend to sit near the threshold, at a large magnitude of either
   // sign, or at zero.
   function automatic logic signed [VOLT_WIDTH-1:0] pick_dc_link();
      int m;
      m = int'(min_dc_level) + $urandom_range(0, 6) - 3;
      case ($urandom_range(0, 7))
         0:       return VOLT_WIDTH'($urandom);
         1:       return VOLT_WIDTH'($urandom_range(0, 1) ? m : -m);
         2:       return '0;
         3:       return 16'sh8000;
         default: return VOLT_WIDTH'($urandom_range(0, 1) ? $urandom_range(8000, 32767)
                                                          : -$urandom_range(8000, 32767));
      endcase
   endfunction

   function automatic req_type random_request();
      req_type r;
      r.alpha_voltage    = pick_reference();
      r.beta_voltage     = pick_reference();
      r.upper_dc_voltage = pick_dc_link();
      r.lower_dc_voltage = pick_dc_link();
      case ($urandom_range(0, 9))
         0:       r.split_factor = $urandom_range(0, 1) ? SPLIT_ONE : 0;
         1, 2:    r.split_factor = GAIN_WIDTH'($urandom);
         default: r.split_factor = GAIN_WIDTH'($urandom_range(0, SPLIT_ONE));
      endcase
      return r;
   endfunction

   function automatic req_type make_request(int a, int b, int k, int vu, int vl);
      req_type r;
      r.alpha_voltage    = VOLT_WIDTH'(a);
      r.beta_voltage     = VOLT_WIDTH'(b);
      r.split_factor     = GAIN_WIDTH'(k);
      r.upper_dc_voltage = VOLT_WIDTH'(vu);
      r.lower_dc_voltage = VOLT_WIDTH'(vl);
      return r;
   endfunction

   // This task waits until every queued beat has been sent and every response has
   // come back. It then lets the pipeline drain fully.
   task automatic wait_idle();
      while (pending_requests.size() > 0 || req_valid || expected_duties.size() > 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_threshold(logic [CSR_WIDTH-1:0] value);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      min_dc_level = value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   initial begin
      int angle_a[12];
      int angle_b[12];
      int per_phase;
      angle_a = '{8000, 6928, 4000, 0, -4000, -6928, -8000, -6928, -4000, 0, 4000, 6928};
      angle_b = '{0, 4000, 6928, 8000, 6928, 4000, 0, -4000, -6928, -8000, -6928, -4000};
      error_count      = 0;
      burst_left       = 1;
      gap_left         = 0;
      stall_mode       = 0;
      stall_count      = 0;
      req_fire         = 1'b0;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_data         = '0;
      rsp_ready        = 1'b0;
      csr_write_enable = 1'b0;
      csr_write_data   = '0;
      min_dc_level     = CSR_RESET;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed beats run with the reset threshold. The twelve reference angles at
      // 30-degree steps cover all six sectors.
      for (int i = 0; i < 12; i++)
         pending_requests.push_back(make_request(angle_a[i], angle_b[i], 8192, 20000, 20000));
      // A zero reference falls back to sector 1.
      pending_requests.push_back(make_request(0, 0, 8192, 20000, -20000));
      // DC links exactly at the threshold and just above it, with both signs.
      pending_requests.push_back(make_request(3000, -2000, 4096, 64, 65));
      pending_requests.push_back(make_request(3000, -2000, 4096, -65, -64));
      // Zero DC link, and the most negative DC link.
      pending_requests.push_back(make_request(-5000, 7000, 12000, 0, -32768));
      // Split factors outside the range saturate to 0 and 1.
      pending_requests.push_back(make_request(9000, 9000, -32768, 30000, 30000));
      pending_requests.push_back(make_request(9000, 9000, 32767, 30000, 30000));
      pending_requests.push_back(make_request(-9000, 200, 16384, 30000, 30000));
      pending_requests.push_back(make_request(-9000, 200, 0, 30000, 30000));
      // References at the extremes, some with small DC links, force clamping and overmodulation.
      pending_requests.push_back(make_request(32767, 32767, 8192, 100, 100));
      pending_requests.push_back(make_request(-32768, -32768, 8192, -32768, 32767));
      pending_requests.push_back(make_request(-32768, 32767, 32767, 32767, -32768));
      wait_idle();

      // The random phases step through several thresholds, including both extremes.
      // At the top threshold, every DC link except -32768 reads as low voltage.
      per_phase = RANDOM_ITEMS / 6;
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0:       write_threshold(CSR_RESET);
            1:       write_threshold('0);
            2:       write_threshold({CSR_WIDTH{1'b1}});
            3:       write_threshold(CSR_WIDTH'($urandom_range(1, 2000)));
            4:       write_threshold(CSR_WIDTH'($urandom));
            default: write_threshold(CSR_WIDTH'(200));
         endcase
         for (int i = 0; i < per_phase; i++) pending_requests.push_back(random_request());
         wait_idle();
      end

      if (error_count == 0) begin
         $display("tb: PASS");
      end else begin
         $display("tb: FAIL");
      end
      $finish;
   end

   initial begin
      #(CLOCK_PERIOD * 400000);
      $display("tb: FAIL");
      $finish;
   end

endmodule

// ===== dual_port_space_vector_modulator.f =====
+incdir+design
design/dpsvm_pkg.sv
design/dpsvm_div_cell.sv
design/dpsvm_div_chain.sv
design/dpsvm_front.sv
design/dpsvm_back.sv
design/dual_port_space_vector_modulator.sv
design/dpsvm_checker.sv
test/tb.sv
